### hw/rtl/clook_pkg.sv
`timescale 1ns / 1ps

package clook_pkg;

   localparam int DEF_MAX_REQUESTS  = 32;
   localparam int DEF_CYLINDER_BITS = 16;

   // fixed field widths on the ports
   localparam int CYL_FIELD_W  = 16;
   localparam int SEEK_W       = 21;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 40;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_POSITION    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREVIOUS_REQUEST = 1'b1;

   typedef enum logic [3:0] {
      S_LOAD   = 4'b0001,
      S_HEAD   = 4'b0010,
      S_FIRST  = 4'b0100,
      S_SECOND = 4'b1000
   } state_type;

   typedef struct packed {
      logic insert;       // store the incoming request
      logic start;        // emit the head and set up the first set
      logic step;         // emit the next entry of the current set
      logic step_second;  // 0: first set, 1: second set
      logic next_set;     // set up the second set
      logic clear;        // batch done, empty both sets
   } cmd_type;

   typedef struct packed {
      logic slot_free;    // output register can take a result this cycle
      logic rem_zero;     // current set has no entries left
   } status_type;

endpackage

### hw/rtl/clook_ctrl.sv
`timescale 1ns / 1ps

module clook_ctrl import clook_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.insert = 1'b1;
               if (req_tlast) state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (status.slot_free) begin
               cmd.start = 1'b1;
               state_in  = S_FIRST;
            end
         end
         S_FIRST: begin
            if (status.rem_zero) begin
               cmd.next_set = 1'b1;
               state_in     = S_SECOND;
            end else if (status.slot_free) begin
               cmd.step = 1'b1;
            end
         end
         S_SECOND: begin
            if (status.rem_zero) begin
               cmd.clear = 1'b1;
               state_in  = S_LOAD;
            end else if (status.slot_free) begin
               cmd.step        = 1'b1;
               cmd.step_second = 1'b1;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else       state_ff <= state_in;
   end

endmodule

### hw/rtl/clook_dp.sv
`timescale 1ns / 1ps

module clook_dp import clook_pkg::*; #(
   parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
   parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int CW    = (CYLINDER_BITS < CYL_FIELD_W) ? CYLINDER_BITS : CYL_FIELD_W;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

   logic [CW-1:0]    head_ff, prev_ff;
   logic [CW-1:0]    lo_ff [MAX_REQUESTS];
   logic [CW-1:0]    hi_ff [MAX_REQUESTS];
   logic [CNT_W-1:0] lo_cnt_ff, lo_cnt_in, hi_cnt_ff, hi_cnt_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in, rem_ff, rem_in;
   logic             desc_ff, desc_in;
   logic [CW-1:0]    curr_ff, curr_in;
   logic [SEEK_W-1:0] seek_ff, seek_in;

   logic                  out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [CW-1:0]         out_cyl_ff, out_cyl_in;
   logic [SEEK_W-1:0]     out_seek_ff, out_seek_in;

   logic [CW-1:0]    req_cyl;
   logic [CNT_W:0]   total;
   logic             room, ins_lo, ins_hi;
   logic [MAX_REQUESTS-1:0] lo_gt, hi_gt;

   logic             desc_now, set_is_lo;
   logic [CNT_W-1:0] first_cnt, second_cnt;
   logic [CW-1:0]    rd_lo, rd_hi, rd_val, step_gap;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         prev_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEAD_POSITION:    head_ff <= csr_wdata[CW-1:0];
            CSR_PREVIOUS_REQUEST: prev_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // sorted insertion: every cell compares against the new value in parallel
   assign req_cyl = req_tdata[CW-1:0];
   assign total   = {1'b0, lo_cnt_ff} + {1'b0, hi_cnt_ff};
   assign room    = (total < (CNT_W+1)'(MAX_REQUESTS));
   assign ins_lo  = cmd.insert && room && (req_cyl < head_ff);
   assign ins_hi  = cmd.insert && room && !(req_cyl < head_ff);

   genvar g;
   generate
      for (g = 0; g < MAX_REQUESTS; g++) begin : g_cell
         logic lo_take_prev, hi_take_prev, lo_take_v, hi_take_v;

         assign lo_gt[g] = (CNT_W'(g) < lo_cnt_ff) && (lo_ff[g] > req_cyl);
         assign hi_gt[g] = (CNT_W'(g) < hi_cnt_ff) && (hi_ff[g] > req_cyl);

         if (g == 0) begin : g_first
            assign lo_take_prev = 1'b0;
            assign hi_take_prev = 1'b0;
         end else begin : g_rest
            assign lo_take_prev = lo_gt[g-1];
            assign hi_take_prev = hi_gt[g-1];
         end

         assign lo_take_v = !lo_take_prev && (lo_gt[g] || (CNT_W'(g) == lo_cnt_ff));
         assign hi_take_v = !hi_take_prev && (hi_gt[g] || (CNT_W'(g) == hi_cnt_ff));

         if (g == 0) begin : g_wr_first
            always_ff @(posedge clock) begin
               if (ins_lo && lo_take_v) lo_ff[g] <= req_cyl;
               if (ins_hi && hi_take_v) hi_ff[g] <= req_cyl;
            end
         end else begin : g_wr_rest
            always_ff @(posedge clock) begin
               if (ins_lo) begin
                  if (lo_take_prev)   lo_ff[g] <= lo_ff[g-1];
                  else if (lo_take_v) lo_ff[g] <= req_cyl;
               end
               if (ins_hi) begin
                  if (hi_take_prev)   hi_ff[g] <= hi_ff[g-1];
                  else if (hi_take_v) hi_ff[g] <= req_cyl;
               end
            end
         end
      end
   endgenerate

   // emission walk
   assign desc_now   = (prev_ff >= head_ff);
   assign first_cnt  = desc_now ? lo_cnt_ff : hi_cnt_ff;
   assign second_cnt = desc_ff ? hi_cnt_ff : lo_cnt_ff;
   assign set_is_lo  = desc_ff ? !cmd.step_second : cmd.step_second;
   assign rd_lo      = lo_ff[ptr_ff[IDX_W-1:0]];
   assign rd_hi      = hi_ff[ptr_ff[IDX_W-1:0]];
   assign rd_val     = set_is_lo ? rd_lo : rd_hi;
   assign step_gap   = (curr_ff >= rd_val) ? (curr_ff - rd_val) : (rd_val - curr_ff);

   assign status.slot_free = !out_valid_ff || rsp_tready;
   assign status.rem_zero  = (rem_ff == '0);

   always_comb begin
      lo_cnt_in   = lo_cnt_ff;
      hi_cnt_in   = hi_cnt_ff;
      ptr_in      = ptr_ff;
      rem_in      = rem_ff;
      desc_in     = desc_ff;
      curr_in     = curr_ff;
      seek_in     = seek_ff;
      out_cyl_in  = out_cyl_ff;
      out_seek_in = out_seek_ff;
      out_last_in = out_last_ff;
      out_valid_in = rsp_tready ? 1'b0 : out_valid_ff;

      if (ins_lo) lo_cnt_in = lo_cnt_ff + 1'b1;
      if (ins_hi) hi_cnt_in = hi_cnt_ff + 1'b1;

      if (cmd.start) begin
         desc_in      = desc_now;
         rem_in       = first_cnt;
         ptr_in       = desc_now ? (first_cnt - 1'b1) : '0;
         curr_in      = head_ff;
         seek_in      = '0;
         out_valid_in = 1'b1;
         out_cyl_in   = head_ff;
         out_seek_in  = '0;
         out_last_in  = (lo_cnt_ff == '0) && (hi_cnt_ff == '0);
      end

      if (cmd.step) begin
         ptr_in       = desc_ff ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);
         rem_in       = rem_ff - 1'b1;
         curr_in      = rd_val;
         seek_in      = seek_ff + SEEK_W'(step_gap);
         out_valid_in = 1'b1;
         out_cyl_in   = rd_val;
         out_seek_in  = seek_ff + SEEK_W'(step_gap);
         out_last_in  = (rem_ff == CNT_W'(1)) && (cmd.step_second || (second_cnt == '0));
      end

      if (cmd.next_set) begin
         rem_in = second_cnt;
         ptr_in = desc_ff ? (second_cnt - 1'b1) : '0;
      end

      if (cmd.clear) begin
         lo_cnt_in = '0;
         hi_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_cnt_ff    <= '0;
         hi_cnt_ff    <= '0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         lo_cnt_ff    <= lo_cnt_in;
         hi_cnt_ff    <= hi_cnt_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      desc_ff     <= desc_in;
      curr_ff     <= curr_in;
      seek_ff     <= seek_in;
      out_cyl_ff  <= out_cyl_in;
      out_seek_ff <= out_seek_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - CYL_FIELD_W - SEEK_W){1'b0}},
                        out_seek_ff, CYL_FIELD_W'(out_cyl_ff)};

endmodule

### hw/rtl/clook_disk_request_scheduler_unit.sv
`timescale 1ns / 1ps
// C-LOOK disk request scheduler.
// req_ channel: one cylinder request per transaction, tdata[15:0] holds the
// cylinder, tlast marks the final request of a batch. Requests are taken one
// per cycle and dropped once MAX_REQUESTS are stored in the batch.
// Each request is inserted into a sorted register row (lower set below
// head_position, upper set otherwise).
// rsp_ channel: after the final request the schedule comes out, head first,
// then every stored request; tdata holds served cylinder and running seek,
// tlast marks the final visit. After the final request the controller enters
// S_HEAD, which loads the head result into the output register; then one
// result per cycle, none on the switch between the sets or on the return to
// loading. The emission walk is one read of the sorted rows per result.
// No request is taken while a schedule is emitted. A stalled rsp_tready
// holds the result in the output register and pauses the walk.
// csr_ port: index 0 head_position, index 1 previous_request; write while idle.
// Reset empties both sets, clears the csr_ registers to zero and drops the output valid.

module clook_disk_request_scheduler_unit import clook_pkg::*; #(
   parameter int MAX_REQUESTS  = DEF_MAX_REQUESTS,
   parameter int CYLINDER_BITS = DEF_CYLINDER_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] request_cylinder
   input  logic                   req_tlast,   // final_request
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] served_cylinder, [36:16] total_seek
   output logic                   rsp_tlast,   // last_in_order
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       ready;

   clook_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (ready),
      .status     (status),
      .cmd        (cmd)
   );

   clook_dp #(
      .MAX_REQUESTS  (MAX_REQUESTS),
      .CYLINDER_BITS (CYLINDER_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = ready;

endmodule
